// ----- hdl/cllfl_pkg.sv -----
// ----------------------------------------------------------------------------
// cllfl_pkg
// Shared sizes, codes and controller/datapath interface types for the
// cursor linked list with free list.
// ----------------------------------------------------------------------------
package cllfl_pkg;

    localparam int POOL_SIZE   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int LIST_CAP    = (MAX_RESULTS < POOL_SIZE) ? MAX_RESULTS : POOL_SIZE;
    localparam int IDX_W       = $clog2(POOL_SIZE);
    localparam int PTR_W       = $clog2(POOL_SIZE + 1);
    localparam int CNT_W       = $clog2(POOL_SIZE + 1);

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SIZE);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_LIST      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FULL,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_CHK,
        S_DEL_FREE,
        S_NOT_FOUND,
        S_LST_RD,
        S_LST_OUT,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    rd;
        logic    rd_sel_free;
        logic    ins_commit;
        logic    del_unlink;
        logic    del_free;
        logic    advance;
        logic    emit;
        t_status emit_code;
        logic    emit_item;
        logic    emit_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       free_null;
        logic       cur_null;
        logic       steps_max;
        logic       match;
        logic       next_null;
        logic       count_max;
        logic       out_free;
    } t_sts;

endpackage

// ----- hdl/cursor_linked_list_with_free_list.sv -----
// ----------------------------------------------------------------------------
// cursor_linked_list_with_free_list
// Singly linked byte list in a fixed node pool with a free list.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata        | tuser                     | tlast
//  s (req)  | in  | [7:0] value  | [1:0] kind                | -
//  m (res)  | out | [7:0] item   | [2:0] status, [3] item_vld| last result
//
//  One request at a time. Insert reads the free head, then links it and
//  emits; delete reads and compares each node visited (up to POOL_SIZE),
//  then unlinks and frees the node on a hit; list reads and emits each
//  node. The node stores are read through a register, so each node takes
//  a read state and then a check or output state. Reset clears heads and
//  link valid bits; no clearing pass. A stalled result holds the list
//  walk; the next request is taken while the last result still waits.
// ----------------------------------------------------------------------------
module cursor_linked_list_with_free_list (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] value
    input  logic [1:0] i_s_tuser,   // [1:0] kind
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] item
    output logic [3:0] o_m_tuser,   // [2:0] status, [3] item_valid
    output logic       o_m_tlast
);

    cllfl_pkg::t_cmd cmd;
    cllfl_pkg::t_sts sts;
    logic [2:0]      out_status;
    logic            out_item_valid;

    cllfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_kind  (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cllfl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_s_tuser),
        .i_value          (i_s_tdata),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_out_status     (out_status),
        .o_out_item       (o_m_tdata),
        .o_out_item_valid (out_item_valid),
        .o_out_last       (o_m_tlast)
    );

    assign o_m_tuser = {out_item_valid, out_status};

endmodule

// ----- hdl/cllfl_dp.sv -----
// ----------------------------------------------------------------------------
// cllfl_dp
// Datapath: node stores, list and free heads, walk cursor and result register.
// ----------------------------------------------------------------------------
module cllfl_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cllfl_pkg::t_cmd   i_cmd,
    output cllfl_pkg::t_sts   o_sts,
    input  logic [1:0]        i_kind,
    input  logic [7:0]        i_value,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_out_status,
    output logic [7:0]        o_out_item,
    output logic              o_out_item_valid,
    output logic              o_out_last
);

    logic [7:0]                  r_val_mem [cllfl_pkg::POOL_SIZE];
    logic [cllfl_pkg::PTR_W-1:0] r_nxt_mem [cllfl_pkg::POOL_SIZE];
    logic [cllfl_pkg::POOL_SIZE-1:0] r_nxt_vld;

    logic [cllfl_pkg::PTR_W-1:0] r_list_head;
    logic [cllfl_pkg::PTR_W-1:0] r_free_head;
    logic [cllfl_pkg::PTR_W-1:0] r_cur;
    logic [cllfl_pkg::PTR_W-1:0] r_prev;
    logic [cllfl_pkg::CNT_W-1:0] r_steps;
    logic [1:0]                  r_kind;
    logic [7:0]                  r_value;
    logic [7:0]                  r_rd_value;
    logic [cllfl_pkg::PTR_W-1:0] r_rd_next;

    logic                        r_out_valid;
    logic [2:0]                  r_out_status;
    logic [7:0]                  r_out_item;
    logic                        r_out_item_valid;
    logic                        r_out_last;

    logic [cllfl_pkg::IDX_W-1:0] rd_addr;
    logic                        wr_en;
    logic [cllfl_pkg::IDX_W-1:0] wr_addr;
    logic [cllfl_pkg::PTR_W-1:0] wr_data;
    logic                        out_free;

    assign rd_addr  = i_cmd.rd_sel_free ? r_free_head[cllfl_pkg::IDX_W-1:0]
                                        : r_cur[cllfl_pkg::IDX_W-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur[cllfl_pkg::IDX_W-1:0];
        wr_data = r_free_head;
        if (i_cmd.ins_commit) begin
            wr_en   = 1'b1;
            wr_addr = r_free_head[cllfl_pkg::IDX_W-1:0];
            wr_data = r_list_head;
        end else if (i_cmd.del_unlink) begin
            wr_en   = (r_prev < cllfl_pkg::NULL_PTR);
            wr_addr = r_prev[cllfl_pkg::IDX_W-1:0];
            wr_data = r_rd_next;
        end else if (i_cmd.del_free) begin
            wr_en   = 1'b1;
            wr_addr = r_cur[cllfl_pkg::IDX_W-1:0];
            wr_data = r_free_head;
        end
    end

    // link store: entries read as their reset chain until first written
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_nxt_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.ins_commit) begin
            r_val_mem[r_free_head[cllfl_pkg::IDX_W-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nxt_vld <= '0;
        end else if (wr_en) begin
            r_nxt_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_value <= r_val_mem[rd_addr];
            if (r_nxt_vld[rd_addr]) begin
                r_rd_next <= r_nxt_mem[rd_addr];
            end else if (rd_addr == '0) begin
                r_rd_next <= cllfl_pkg::NULL_PTR;
            end else begin
                r_rd_next <= cllfl_pkg::PTR_W'(rd_addr) - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_head <= cllfl_pkg::NULL_PTR;
            r_free_head <= cllfl_pkg::PTR_W'(cllfl_pkg::POOL_SIZE - 1);
        end else begin
            if (i_cmd.ins_commit) begin
                r_list_head <= r_free_head;
                r_free_head <= r_rd_next;
            end
            if (i_cmd.del_unlink && !(r_prev < cllfl_pkg::NULL_PTR)) begin
                r_list_head <= r_rd_next;
            end
            if (i_cmd.del_free) begin
                r_free_head <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_cur   <= r_list_head;
            r_prev  <= cllfl_pkg::NULL_PTR;
            r_steps <= '0;
        end else if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_next;
            r_steps <= r_steps + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status     <= i_cmd.emit_code;
            r_out_item       <= i_cmd.emit_item ? r_rd_value : 8'd0;
            r_out_item_valid <= i_cmd.emit_item;
            r_out_last       <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_sts.kind      = r_kind;
        o_sts.free_null = !(r_free_head < cllfl_pkg::NULL_PTR);
        o_sts.cur_null  = !(r_cur < cllfl_pkg::NULL_PTR);
        o_sts.steps_max = (r_steps >= cllfl_pkg::CNT_W'(cllfl_pkg::POOL_SIZE));
        o_sts.match     = (r_rd_value == r_value);
        o_sts.next_null = !(r_rd_next < cllfl_pkg::NULL_PTR);
        o_sts.count_max = (r_steps >= cllfl_pkg::CNT_W'(cllfl_pkg::LIST_CAP - 1));
        o_sts.out_free  = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_item       = r_out_item;
    assign o_out_item_valid = r_out_item_valid;
    assign o_out_last       = r_out_last;

endmodule

// ----- hdl/cllfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// cllfl_ctrl
// Controller: sequences insert, delete walk and list walk over the datapath.
// ----------------------------------------------------------------------------
module cllfl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_kind,
    output logic            o_in_ready,
    input  cllfl_pkg::t_sts i_sts,
    output cllfl_pkg::t_cmd o_cmd
);

    cllfl_pkg::t_state r_state;
    cllfl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cllfl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            cllfl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    // drop unused kind codes
                    if (i_in_kind == cllfl_pkg::KIND_INSERT ||
                        i_in_kind == cllfl_pkg::KIND_DELETE ||
                        i_in_kind == cllfl_pkg::KIND_LIST) begin
                        n_state = cllfl_pkg::S_DISPATCH;
                    end
                end
            end
            cllfl_pkg::S_DISPATCH: begin
                if (i_sts.kind == cllfl_pkg::KIND_INSERT) begin
                    if (i_sts.free_null) begin
                        n_state = cllfl_pkg::S_FULL;
                    end else begin
                        o_cmd.rd          = 1'b1;
                        o_cmd.rd_sel_free = 1'b1;
                        n_state           = cllfl_pkg::S_INS_WR;
                    end
                end else if (i_sts.kind == cllfl_pkg::KIND_DELETE) begin
                    n_state = cllfl_pkg::S_DEL_RD;
                end else if (i_sts.cur_null) begin
                    n_state = cllfl_pkg::S_EMPTY;
                end else begin
                    n_state = cllfl_pkg::S_LST_RD;
                end
            end
            cllfl_pkg::S_FULL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_code = cllfl_pkg::ST_FULL;
                    o_cmd.emit_last = 1'b1;
                    n_state         = cllfl_pkg::S_IDLE;
                end
            end
            cllfl_pkg::S_INS_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.ins_commit = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_code  = cllfl_pkg::ST_INSERTED;
                    o_cmd.emit_last  = 1'b1;
                    n_state          = cllfl_pkg::S_IDLE;
                end
            end
            cllfl_pkg::S_DEL_RD: begin
                if (i_sts.cur_null || i_sts.steps_max) begin
                    n_state = cllfl_pkg::S_NOT_FOUND;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = cllfl_pkg::S_DEL_CHK;
                end
            end
            cllfl_pkg::S_DEL_CHK: begin
                if (i_sts.match) begin
                    o_cmd.del_unlink = 1'b1;
                    n_state          = cllfl_pkg::S_DEL_FREE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = cllfl_pkg::S_DEL_RD;
                end
            end
            cllfl_pkg::S_DEL_FREE: begin
                if (i_sts.out_free) begin
                    o_cmd.del_free  = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_code = cllfl_pkg::ST_DELETED;
                    o_cmd.emit_last = 1'b1;
                    n_state         = cllfl_pkg::S_IDLE;
                end
            end
            cllfl_pkg::S_NOT_FOUND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_code = cllfl_pkg::ST_NOT_FOUND;
                    o_cmd.emit_last = 1'b1;
                    n_state         = cllfl_pkg::S_IDLE;
                end
            end
            cllfl_pkg::S_LST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = cllfl_pkg::S_LST_OUT;
            end
            cllfl_pkg::S_LST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_code = cllfl_pkg::ST_LIST;
                    o_cmd.emit_item = 1'b1;
                    o_cmd.emit_last = i_sts.next_null || i_sts.count_max;
                    if (i_sts.next_null || i_sts.count_max) begin
                        n_state = cllfl_pkg::S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = cllfl_pkg::S_LST_RD;
                    end
                end
            end
            cllfl_pkg::S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_code = cllfl_pkg::ST_LIST;
                    o_cmd.emit_last = 1'b1;
                    n_state         = cllfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cllfl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/cllfl_chk.sv -----
// ----------------------------------------------------------------------------
// cllfl_chk
// Port-level checks for the linked list block, bound to the top level.
// ----------------------------------------------------------------------------
module cllfl_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic [1:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [3:0] o_m_tuser,
    input logic       o_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
            $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != cllfl_pkg::KIND_UNUSED |=>
            !o_s_tready)
        else $error("request taken while one is in progress");

    a_item_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3] |-> o_m_tuser[2:0] == cllfl_pkg::ST_LIST)
        else $error("listed item with wrong status");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:0] != cllfl_pkg::ST_LIST |-> o_m_tlast)
        else $error("insert or delete result not marked last");

    a_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[3] |-> o_m_tdata == 8'd0)
        else $error("item nonzero without item_valid");

endmodule

bind cursor_linked_list_with_free_list cllfl_chk u_chk (.*);
